/* rtl/core/dtt_pkg.sv */
// Package for the deadline timer table: widths, codes, slot entry type and
// the sequencer state type. No dependencies.

package dtt_pkg;

	localparam int SLOTS_DEF  = 8;
	localparam int TYPE_COUNT = 4;
	localparam int ID_COUNT   = 8;
	localparam int DL_W       = 32;
	localparam int ID_W       = 4;
	localparam int TY_W       = 4;
	localparam int CNT_W      = 4;
	localparam int ST_W       = 3;

	localparam logic [DL_W-1:0] NO_DEADLINE = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_DEL   = 2'd1,
		OP_SHIFT = 2'd2,
		OP_ALARM = 2'd3
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		STS_OK       = 3'd0,
		STS_REJECTED = 3'd1,
		STS_NO_TIMER = 3'd2,
		STS_PASSED   = 3'd3,
		STS_BAD_ID   = 3'd4,
		STS_EMPTY    = 3'd5,
		STS_EXPIRED  = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_SCAN,
		S_INS_WR,
		S_MIN_SCAN,
		S_SELECT,
		S_SHIFT_SCAN,
		S_SHIFT_ARMED,
		S_REARM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [TY_W-1:0] ty;
		logic [ID_W-1:0] id;
		logic [DL_W-1:0] dl;
	} slot_entry_t;

	function automatic logic type_ok(input logic [TY_W-1:0] t);
		return (t != '0) && ({1'b0, t} < (TY_W+1)'(TYPE_COUNT));
	endfunction

endpackage

/* rtl/core/dtt_alu.sv */
// Shared 32-bit adder/subtractor of the deadline timer table.
// Depends on dtt_pkg for the deadline width.

module dtt_alu (
	input  logic [dtt_pkg::DL_W-1:0] a,
	input  logic [dtt_pkg::DL_W-1:0] b,
	input  logic                     sub,
	output logic [dtt_pkg::DL_W-1:0] result,
	output logic                     lt
);

	logic [dtt_pkg::DL_W:0] sum;
	logic [dtt_pkg::DL_W-1:0] b_op;

	always_comb begin
		b_op   = sub ? ~b : b;
		sum    = {1'b0, a} + {1'b0, b_op} + (dtt_pkg::DL_W+1)'(sub);
		result = sum[dtt_pkg::DL_W-1:0];
		// Subtraction borrows exactly when a is below b.
		lt     = sub & ~sum[dtt_pkg::DL_W];
	end

endmodule

/* rtl/core/dtt_slot_file.sv */
// Slot storage of the deadline timer table: one read index, one write port.
// Depends on dtt_pkg for the slot entry type.

module dtt_slot_file #(
	parameter int SLOTS = dtt_pkg::SLOTS_DEF,
	localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IW-1:0]        rd_idx,
	output dtt_pkg::slot_entry_t rd_data,
	input  logic                 wr_en,
	input  logic [IW-1:0]        wr_idx,
	input  dtt_pkg::slot_entry_t wr_data
);

	logic [dtt_pkg::TY_W-1:0] ty_q [SLOTS];
	logic [dtt_pkg::ID_W-1:0] id_q [SLOTS];
	logic [dtt_pkg::DL_W-1:0] dl_q [SLOTS];

	// A zero type marks a free slot, so only the types need a reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				ty_q[i] <= '0;
			end
		end else if (wr_en) begin
			ty_q[wr_idx] <= wr_data.ty;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q[wr_idx] <= wr_data.id;
			dl_q[wr_idx] <= wr_data.dl;
		end
	end

	always_comb begin
		rd_data.ty = ty_q[rd_idx];
		rd_data.id = id_q[rd_idx];
		rd_data.dl = dl_q[rd_idx];
	end

endmodule

/* rtl/core/deadline_timer_table_core.sv */
// Top level of the deadline timer table: sequencer, armed timer and result register.
// Depends on dtt_pkg, dtt_alu and dtt_slot_file.
//
//   channel  signals                                                   direction
//   input    in_valid/in_ready: opcode, instance_id, timer_type,      into block
//            deadline, now_seconds, delta, shift_down
//   output   out_valid/out_ready: status, alarm_valid,                 out of block
//            alarm_seconds, current_id
//
// An add scans the slots twice, a delete and a shift once each, and an alarm check
// scans none; the slot scans go through one shared adder.
// One item is in work at a time; in_ready is high only while the sequencer is idle.
// A finished result waits in the output register; a new transfer is taken meanwhile
// and its result stalls in the last step until the register is free.
// Reset clears all slots, the armed timer and the valid count at once.

module deadline_timer_table_core #(
	parameter int SLOTS = dtt_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [3:0]  instance_id,
	input  logic [3:0]  timer_type,
	input  logic [31:0] deadline,
	input  logic [31:0] now_seconds,
	input  logic [31:0] delta,
	input  logic        shift_down,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        alarm_valid,
	output logic [31:0] alarm_seconds,
	output logic [3:0]  current_id
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = dtt_pkg::CNT_W;

	dtt_pkg::state_t state_q, state_d;

	dtt_pkg::opcode_t             op_q;
	logic [dtt_pkg::ID_W-1:0]     id_q;
	logic [dtt_pkg::TY_W-1:0]     ty_q;
	logic [dtt_pkg::DL_W-1:0]     dl_q;
	logic [dtt_pkg::DL_W-1:0]     now_q;
	logic [dtt_pkg::DL_W-1:0]     delta_q;
	logic                         down_q;

	logic [IW-1:0]                scan_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                valid_count_q;
	logic                         match_found_q, free_found_q, best_found_q;
	logic [IW-1:0]                match_idx_q, free_idx_q, best_idx_q;
	dtt_pkg::slot_entry_t         best_q;
	dtt_pkg::slot_entry_t         armed_q;

	dtt_pkg::status_t             res_status_q;
	logic                         res_alarm_q;
	logic [dtt_pkg::DL_W-1:0]     res_secs_q;

	logic                         out_valid_q;
	dtt_pkg::status_t             out_status_q;
	logic                         out_alarm_q;
	logic [dtt_pkg::DL_W-1:0]     out_secs_q;
	logic [dtt_pkg::ID_W-1:0]     out_id_q;

	dtt_pkg::slot_entry_t         rd_data, wr_data;
	logic                         wr_en;
	logic [IW-1:0]                wr_idx;

	logic [dtt_pkg::DL_W-1:0]     alu_a, alu_b, alu_r;
	logic                         alu_sub, alu_lt;

	logic                         scan_last, rd_ok, kill, eff_valid, future;

	dtt_alu u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.sub    (alu_sub),
		.result (alu_r),
		.lt     (alu_lt)
	);

	dtt_slot_file #(.SLOTS(SLOTS)) u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (scan_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	assign in_ready      = (state_q == dtt_pkg::S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign alarm_valid   = out_alarm_q;
	assign alarm_seconds = out_secs_q;
	assign current_id    = out_id_q;

	always_comb begin
		scan_last = (scan_q == IW'(SLOTS - 1));
		rd_ok     = dtt_pkg::type_ok(rd_data.ty);
		kill      = (op_q == dtt_pkg::OP_DEL) && rd_ok && (rd_data.id == id_q);
		eff_valid = rd_ok && !kill;
		future    = !alu_lt && (alu_r != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		wr_en   = 1'b0;
		wr_idx  = scan_q;
		wr_data = rd_data;
		unique case (state_q)
			dtt_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = dtt_pkg::S_DISPATCH;
				end
			end
			dtt_pkg::S_DISPATCH: begin
				unique case (op_q)
					dtt_pkg::OP_ADD: begin
						if (valid_count_q >= CW'(SLOTS) || !dtt_pkg::type_ok(ty_q)) begin
							state_d = dtt_pkg::S_DONE;
						end else begin
							state_d = dtt_pkg::S_INS_SCAN;
						end
					end
					dtt_pkg::OP_DEL: begin
						if ({1'b0, id_q} >= (dtt_pkg::ID_W+1)'(dtt_pkg::ID_COUNT) ||
						    valid_count_q == '0) begin
							state_d = dtt_pkg::S_DONE;
						end else begin
							state_d = dtt_pkg::S_MIN_SCAN;
						end
					end
					dtt_pkg::OP_SHIFT: begin
						state_d = (delta_q == '0) ? dtt_pkg::S_DONE : dtt_pkg::S_SHIFT_SCAN;
					end
					dtt_pkg::OP_ALARM: begin
						state_d = dtt_pkg::S_REARM;
					end
					default: begin
						state_d = dtt_pkg::S_DONE;
					end
				endcase
			end
			dtt_pkg::S_INS_SCAN: begin
				if (scan_last) begin
					state_d = dtt_pkg::S_INS_WR;
				end
			end
			dtt_pkg::S_INS_WR: begin
				wr_data = '{ty: ty_q, id: id_q, dl: dl_q};
				if (match_found_q) begin
					wr_en   = 1'b1;
					wr_idx  = match_idx_q;
					state_d = dtt_pkg::S_MIN_SCAN;
				end else if (armed_q.id == id_q) begin
					state_d = dtt_pkg::S_MIN_SCAN;
				end else if (free_found_q) begin
					wr_en   = 1'b1;
					wr_idx  = free_idx_q;
					state_d = dtt_pkg::S_MIN_SCAN;
				end else begin
					state_d = dtt_pkg::S_DONE;
				end
			end
			dtt_pkg::S_MIN_SCAN: begin
				alu_a   = rd_data.dl;
				alu_b   = best_q.dl;
				alu_sub = 1'b1;
				if (kill) begin
					wr_en   = 1'b1;
					wr_data = '{ty: '0, id: rd_data.id, dl: rd_data.dl};
				end
				if (scan_last) begin
					state_d = dtt_pkg::S_SELECT;
				end
			end
			dtt_pkg::S_SELECT: begin
				alu_a   = best_q.dl;
				alu_b   = armed_q.dl;
				alu_sub = 1'b1;
				wr_idx  = best_idx_q;
				state_d = dtt_pkg::S_DONE;
				if (op_q == dtt_pkg::OP_ADD) begin
					if (best_found_q) begin
						state_d = dtt_pkg::S_REARM;
						if (alu_lt) begin
							wr_en   = 1'b1;
							wr_data = armed_q;
						end
					end
				end else if (armed_q.id == id_q && best_found_q) begin
					wr_en   = 1'b1;
					wr_data = '{ty: '0, id: best_q.id, dl: best_q.dl};
					state_d = dtt_pkg::S_REARM;
				end
			end
			dtt_pkg::S_SHIFT_SCAN: begin
				alu_a   = rd_data.dl;
				alu_b   = delta_q;
				alu_sub = down_q;
				if (rd_ok) begin
					wr_en   = 1'b1;
					wr_data = '{ty: rd_data.ty, id: rd_data.id, dl: alu_r};
				end
				if (scan_last) begin
					state_d = dtt_pkg::S_SHIFT_ARMED;
				end
			end
			dtt_pkg::S_SHIFT_ARMED: begin
				alu_a   = armed_q.dl;
				alu_b   = delta_q;
				alu_sub = down_q;
				state_d = dtt_pkg::S_REARM;
			end
			dtt_pkg::S_REARM: begin
				alu_a   = armed_q.dl;
				alu_b   = now_q;
				alu_sub = 1'b1;
				state_d = dtt_pkg::S_DONE;
			end
			dtt_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = dtt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dtt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= '0;
			valid_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				dtt_pkg::S_INS_WR: begin
					if (!match_found_q && armed_q.id == id_q) begin
						armed_q.ty <= ty_q;
						armed_q.dl <= dl_q;
					end
				end
				dtt_pkg::S_SELECT: begin
					if (op_q == dtt_pkg::OP_ADD) begin
						valid_count_q <= count_q;
						if (best_found_q && alu_lt) begin
							armed_q <= best_q;
							if (!dtt_pkg::type_ok(armed_q.ty)) begin
								valid_count_q <= count_q - 1'b1;
							end
						end
					end else begin
						valid_count_q <= count_q;
						if (armed_q.id == id_q && best_found_q) begin
							armed_q       <= best_q;
							valid_count_q <= count_q - 1'b1;
						end
					end
				end
				dtt_pkg::S_SHIFT_ARMED: begin
					armed_q.dl <= alu_r;
				end
				dtt_pkg::S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dtt_pkg::S_IDLE: begin
				op_q    <= dtt_pkg::opcode_t'(opcode);
				id_q    <= instance_id;
				ty_q    <= timer_type;
				dl_q    <= deadline;
				now_q   <= now_seconds;
				delta_q <= delta;
				down_q  <= shift_down;
			end
			dtt_pkg::S_DISPATCH: begin
				res_status_q  <= dtt_pkg::STS_OK;
				res_alarm_q   <= 1'b0;
				res_secs_q    <= '0;
				scan_q        <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				best_found_q  <= 1'b0;
				best_q.dl     <= dtt_pkg::NO_DEADLINE;
				count_q       <= '0;
				unique case (op_q)
					dtt_pkg::OP_ADD: begin
						if (valid_count_q >= CW'(SLOTS) || !dtt_pkg::type_ok(ty_q)) begin
							res_status_q <= dtt_pkg::STS_REJECTED;
						end
					end
					dtt_pkg::OP_DEL: begin
						if ({1'b0, id_q} >= (dtt_pkg::ID_W+1)'(dtt_pkg::ID_COUNT)) begin
							res_status_q <= dtt_pkg::STS_BAD_ID;
						end else if (valid_count_q == '0) begin
							res_status_q <= dtt_pkg::STS_EMPTY;
						end
					end
					default: begin
					end
				endcase
			end
			dtt_pkg::S_INS_SCAN: begin
				scan_q <= scan_q + 1'b1;
				if (rd_ok && rd_data.id == id_q && !match_found_q) begin
					match_found_q <= 1'b1;
					match_idx_q   <= scan_q;
				end
				if (rd_data.ty == '0 && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= scan_q;
				end
				if (scan_last) begin
					scan_q <= '0;
				end
			end
			dtt_pkg::S_INS_WR: begin
				if (!match_found_q && armed_q.id != id_q && !free_found_q) begin
					res_status_q <= dtt_pkg::STS_REJECTED;
				end
			end
			dtt_pkg::S_MIN_SCAN: begin
				scan_q  <= scan_q + 1'b1;
				count_q <= count_q + CW'(eff_valid);
				if (eff_valid && alu_lt) begin
					best_q       <= rd_data;
					best_idx_q   <= scan_q;
					best_found_q <= 1'b1;
				end
			end
			dtt_pkg::S_SELECT: begin
				if (op_q == dtt_pkg::OP_ADD || armed_q.id == id_q) begin
					if (!best_found_q) begin
						res_status_q <= dtt_pkg::STS_NO_TIMER;
					end
				end
			end
			dtt_pkg::S_SHIFT_SCAN: begin
				scan_q <= scan_q + 1'b1;
			end
			dtt_pkg::S_REARM: begin
				if (future) begin
					res_alarm_q <= 1'b1;
					res_secs_q  <= alu_r;
				end else if (op_q == dtt_pkg::OP_ALARM) begin
					res_status_q <= dtt_pkg::STS_EXPIRED;
				end else begin
					res_status_q <= dtt_pkg::STS_PASSED;
				end
			end
			dtt_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_status_q <= res_status_q;
					out_alarm_q  <= res_alarm_q;
					out_secs_q   <= res_secs_q;
					out_id_q     <= armed_q.id;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* tb/sv/deadline_timer_table_core_tb.sv */
// Testbench for deadline_timer_table_core: a directed table, then random timer commands.
// Fixed directed rows are checked against their expected results in the table; every other
// result against an in-bench earliest-deadline table predictor. Depends on dtt_pkg and the core RTL only.

module deadline_timer_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_SLOTS = dtt_pkg::SLOTS_DEF;
	localparam int DIR_N = 25;
	localparam int RAND_N = 1750;

	typedef struct packed {
		dtt_pkg::opcode_t op;
		logic [3:0]       id;
		logic [3:0]       ty;
		logic [31:0]      dl;
		logic [31:0]      now;
		logic [31:0]      dlt;
		logic             down;
	} timer_cmd_t;

	typedef struct packed {
		dtt_pkg::status_t sts;
		logic             alarm;
		logic [31:0]      secs;
		logic [3:0]       cur;
	} timer_rsp_t;

	typedef struct packed {
		timer_cmd_t cmd;
		logic       fixed;
		timer_rsp_t rsp;
	} table_row_t;

	localparam timer_rsp_t NO_RSP = '{dtt_pkg::STS_OK, 1'b0, 32'd0, 4'd0};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	logic [3:0]  instance_id;
	logic [3:0]  timer_type;
	logic [31:0] deadline;
	logic [31:0] now_seconds;
	logic [31:0] delta;
	logic        shift_down;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic        alarm_valid;
	logic [31:0] alarm_seconds;
	logic [3:0]  current_id;

	logic [3:0]  tbl_ty [N_SLOTS];
	logic [3:0]  tbl_id [N_SLOTS];
	logic [31:0] tbl_dl [N_SLOTS];
	logic [3:0]  arm_ty;
	logic [3:0]  arm_id;
	logic [31:0] arm_dl;
	int          live_n;
	logic [31:0] wall;

	timer_rsp_t outcome_q [$];
	int mismatches = 0;
	int checked = 0;
	int sent = 0;
	int sts_hits [8];

	table_row_t dir_rows [DIR_N] = '{
		'{'{dtt_pkg::OP_ALARM, 4'd0, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0},
		  1'b1, '{dtt_pkg::STS_EXPIRED, 1'b0, 32'd0, 4'd0}},
		'{'{dtt_pkg::OP_DEL, 4'd8, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0},
		  1'b1, '{dtt_pkg::STS_BAD_ID, 1'b0, 32'd0, 4'd0}},
		'{'{dtt_pkg::OP_DEL, 4'd15, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0},
		  1'b1, '{dtt_pkg::STS_BAD_ID, 1'b0, 32'd0, 4'd0}},
		'{'{dtt_pkg::OP_DEL, 4'd3, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0},
		  1'b1, '{dtt_pkg::STS_EMPTY, 1'b0, 32'd0, 4'd0}},
		'{'{dtt_pkg::OP_ADD, 4'd5, 4'd0, 32'd10, 32'd0, 32'd0, 1'b0},
		  1'b1, '{dtt_pkg::STS_REJECTED, 1'b0, 32'd0, 4'd0}},
		'{'{dtt_pkg::OP_ADD, 4'd5, 4'd4, 32'd10, 32'd0, 32'd0, 1'b0},
		  1'b1, '{dtt_pkg::STS_REJECTED, 1'b0, 32'd0, 4'd0}},
		'{'{dtt_pkg::OP_ADD, 4'd5, 4'd15, 32'd10, 32'd0, 32'd0, 1'b0},
		  1'b1, '{dtt_pkg::STS_REJECTED, 1'b0, 32'd0, 4'd0}},
		'{'{dtt_pkg::OP_SHIFT, 4'd0, 4'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1},
		  1'b1, '{dtt_pkg::STS_OK, 1'b0, 32'd0, 4'd0}},
		'{'{dtt_pkg::OP_ADD, 4'd0, 4'd1, 32'd100, 32'd10, 32'd0, 1'b0}, 1'b0, NO_RSP},
		'{'{dtt_pkg::OP_ADD, 4'd1, 4'd3, 32'd50, 32'd10, 32'd0, 1'b0}, 1'b0, NO_RSP},
		'{'{dtt_pkg::OP_ADD, 4'd2, 4'd2, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0},
		  1'b0, NO_RSP},
		'{'{dtt_pkg::OP_ADD, 4'd6, 4'd3, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0},
		  1'b0, NO_RSP},
		'{'{dtt_pkg::OP_ADD, 4'd3, 4'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0},
		  1'b0, NO_RSP},
		'{'{dtt_pkg::OP_ALARM, 4'd0, 4'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0},
		  1'b0, NO_RSP},
		'{'{dtt_pkg::OP_ALARM, 4'd0, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, NO_RSP},
		'{'{dtt_pkg::OP_SHIFT, 4'd0, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0},
		  1'b0, NO_RSP},
		'{'{dtt_pkg::OP_SHIFT, 4'd0, 4'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1},
		  1'b0, NO_RSP},
		'{'{dtt_pkg::OP_DEL, 4'd7, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, NO_RSP},
		'{'{dtt_pkg::OP_DEL, 4'd3, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, NO_RSP},
		'{'{dtt_pkg::OP_DEL, 4'd1, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, NO_RSP},
		'{'{dtt_pkg::OP_DEL, 4'd0, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, NO_RSP},
		'{'{dtt_pkg::OP_DEL, 4'd2, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, NO_RSP},
		'{'{dtt_pkg::OP_ADD, 4'd5, 4'd2, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0},
		  1'b0, NO_RSP},
		'{'{dtt_pkg::OP_DEL, 4'd6, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, NO_RSP},
		'{'{dtt_pkg::OP_ALARM, 4'd0, 4'd0, 32'd0, 32'hAAAA_AAAA, 32'd0, 1'b0},
		  1'b0, NO_RSP}
	};

	deadline_timer_table_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.instance_id   (instance_id),
		.timer_type    (timer_type),
		.deadline      (deadline),
		.now_seconds   (now_seconds),
		.delta         (delta),
		.shift_down    (shift_down),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.alarm_valid   (alarm_valid),
		.alarm_seconds (alarm_seconds),
		.current_id    (current_id)
	);

	always #1 clk = ~clk;

	function automatic bit type_armable(logic [3:0] t);
		return (t != 4'd0) && (t < dtt_pkg::TYPE_COUNT);
	endfunction

	function automatic void retally();
		live_n = 0;
		for (int i = 0; i < N_SLOTS; i++)
			if (type_armable(tbl_ty[i])) live_n++;
	endfunction

	function automatic void clear_table();
		for (int i = 0; i < N_SLOTS; i++) begin
			tbl_ty[i] = 4'd0;
			tbl_id[i] = 4'd0;
			tbl_dl[i] = 32'd0;
		end
		arm_ty = 4'd0;
		arm_id = 4'd0;
		arm_dl = 32'd0;
		live_n = 0;
		wall = 32'd1000;
	endfunction

	function automatic bit earliest_slot(output int at);
		logic [31:0] low;
		low = dtt_pkg::NO_DEADLINE;
		at = N_SLOTS;
		if (live_n == 0) return 1'b0;
		for (int i = 0; i < N_SLOTS; i++) begin
			if (type_armable(tbl_ty[i]) && tbl_dl[i] < low) begin
				low = tbl_dl[i];
				at = i;
			end
		end
		return at < N_SLOTS;
	endfunction

	function automatic bit stow(logic [3:0] id, logic [3:0] ty, logic [31:0] dl);
		if (live_n >= N_SLOTS || !type_armable(ty)) return 1'b0;
		for (int i = 0; i < N_SLOTS; i++) begin
			if (type_armable(tbl_ty[i]) && tbl_id[i] == id) begin
				tbl_ty[i] = ty;
				tbl_dl[i] = dl;
				return 1'b1;
			end
		end
		if (arm_id == id) begin
			arm_ty = ty;
			arm_dl = dl;
			return 1'b1;
		end
		for (int i = 0; i < N_SLOTS; i++) begin
			if (tbl_ty[i] == 4'd0) begin
				tbl_ty[i] = ty;
				tbl_id[i] = id;
				tbl_dl[i] = dl;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic timer_rsp_t timer_outcome(timer_cmd_t c);
		timer_rsp_t r;
		int at;
		logic [3:0] t_ty, t_id;
		logic [31:0] t_dl;
		r = NO_RSP;
		case (c.op)
			dtt_pkg::OP_ADD: begin
				if (!stow(c.id, c.ty, c.dl)) begin
					r.sts = dtt_pkg::STS_REJECTED;
				end else begin
					retally();
					if (!earliest_slot(at)) begin
						r.sts = dtt_pkg::STS_NO_TIMER;
					end else begin
						if (tbl_dl[at] < arm_dl) begin
							t_ty = tbl_ty[at];
							t_id = tbl_id[at];
							t_dl = tbl_dl[at];
							tbl_ty[at] = arm_ty;
							tbl_id[at] = arm_id;
							tbl_dl[at] = arm_dl;
							arm_ty = t_ty;
							arm_id = t_id;
							arm_dl = t_dl;
						end
						r.alarm = arm_dl > c.now;
						if (!r.alarm) r.sts = dtt_pkg::STS_PASSED;
					end
				end
			end
			dtt_pkg::OP_DEL: begin
				if (c.id >= dtt_pkg::ID_COUNT) begin
					r.sts = dtt_pkg::STS_BAD_ID;
				end else if (live_n == 0) begin
					r.sts = dtt_pkg::STS_EMPTY;
				end else begin
					for (int i = 0; i < N_SLOTS; i++)
						if (type_armable(tbl_ty[i]) && tbl_id[i] == c.id) tbl_ty[i] = 4'd0;
					retally();
					if (arm_id == c.id) begin
						if (!earliest_slot(at)) begin
							r.sts = dtt_pkg::STS_NO_TIMER;
						end else begin
							arm_ty = tbl_ty[at];
							arm_id = tbl_id[at];
							arm_dl = tbl_dl[at];
							tbl_ty[at] = 4'd0;
							r.alarm = arm_dl > c.now;
							if (!r.alarm) r.sts = dtt_pkg::STS_PASSED;
						end
					end
				end
			end
			dtt_pkg::OP_SHIFT: begin
				if (c.dlt != 32'd0) begin
					for (int i = 0; i < N_SLOTS; i++)
						if (type_armable(tbl_ty[i]))
							tbl_dl[i] = c.down ? tbl_dl[i] - c.dlt : tbl_dl[i] + c.dlt;
					arm_dl = c.down ? arm_dl - c.dlt : arm_dl + c.dlt;
					r.alarm = arm_dl > c.now;
					if (!r.alarm) r.sts = dtt_pkg::STS_PASSED;
				end
			end
			default: begin
				r.alarm = arm_dl > c.now;
				if (!r.alarm) r.sts = dtt_pkg::STS_EXPIRED;
			end
		endcase
		retally();
		if (r.alarm) r.secs = arm_dl - c.now;
		r.cur = arm_id;
		return r;
	endfunction

	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic timer_cmd_t roll_cmd(int idx);
		timer_cmd_t c;
		int pick, hi_n, v;
		bit filling;
		filling = ((idx / 120) % 2) == 0;
		pick = $urandom_range(0, 99);
		c.id = 4'($urandom);
		c.ty = 4'($urandom);
		c.dl = $urandom;
		c.now = $urandom;
		c.dlt = $urandom;
		c.down = 1'($urandom);
		if (filling)
			c.op = pick < 60 ? dtt_pkg::OP_ADD : pick < 75 ? dtt_pkg::OP_DEL :
				pick < 85 ? dtt_pkg::OP_SHIFT : dtt_pkg::OP_ALARM;
		else
			c.op = pick < 20 ? dtt_pkg::OP_ADD : pick < 70 ? dtt_pkg::OP_DEL :
				pick < 80 ? dtt_pkg::OP_SHIFT : dtt_pkg::OP_ALARM;
		wall = wall + 32'($urandom_range(0, 20));
		if ($urandom_range(0, 15) != 0) c.now = wall;
		case (c.op)
			dtt_pkg::OP_ADD: begin
				hi_n = (arm_id >= dtt_pkg::ID_COUNT) ? 1 : 0;
				for (int i = 0; i < N_SLOTS; i++)
					if (type_armable(tbl_ty[i]) && tbl_id[i] >= dtt_pkg::ID_COUNT) hi_n++;
				if ($urandom_range(0, 15) == 0 && hi_n < 2)
					c.id = 4'($urandom_range(dtt_pkg::ID_COUNT, 15));
				else
					c.id = 4'($urandom_range(0, dtt_pkg::ID_COUNT - 1));
				if ($urandom_range(0, 9) == 0) begin
					v = $urandom_range(dtt_pkg::TYPE_COUNT - 1, 15);
					c.ty = (v == dtt_pkg::TYPE_COUNT - 1) ? 4'd0 : 4'(v);
				end else begin
					c.ty = 4'($urandom_range(1, dtt_pkg::TYPE_COUNT - 1));
				end
				case ($urandom_range(0, 15))
					0: c.dl = dtt_pkg::NO_DEADLINE;
					1: c.dl = $urandom;
					2: c.dl = 32'd0;
					default: c.dl = wall + 32'($urandom_range(0, 400)) - 32'd40;
				endcase
			end
			dtt_pkg::OP_DEL: begin
				v = $urandom_range(0, 15);
				if (v == 0) c.id = 4'($urandom_range(dtt_pkg::ID_COUNT, 15));
				else if (v < 6) c.id = arm_id;
				else c.id = 4'($urandom_range(0, dtt_pkg::ID_COUNT - 1));
			end
			dtt_pkg::OP_SHIFT: begin
				case ($urandom_range(0, 7))
					0: c.dlt = 32'd0;
					1: c.dlt = $urandom;
					default: c.dlt = 32'($urandom_range(1, 300));
				endcase
			end
			default: ;
		endcase
		return c;
	endfunction

	task automatic flag_mismatch(string what);
		mismatches++;
		$display("ERROR at %0t ns: %s", $time, what);
	endtask

	task automatic offer_cmd(timer_cmd_t c, bit fixed, timer_rsp_t typed, bit calm);
		timer_rsp_t got;
		int gap;
		gap = pick_gap(calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= c.op;
		instance_id <= c.id;
		timer_type <= c.ty;
		deadline <= c.dl;
		now_seconds <= c.now;
		delta <= c.dlt;
		shift_down <= c.down;
		do @(posedge clk); while (!in_ready);
		got = timer_outcome(c);
		sts_hits[got.sts]++;
		outcome_q.push_back(fixed ? typed : got);
		sent++;
	endtask

	task automatic check_outcome();
		timer_rsp_t want;
		if (outcome_q.size() == 0) begin
			flag_mismatch($sformatf("result with nothing pending, status %0d", status));
			return;
		end
		want = outcome_q.pop_front();
		checked++;
		if (status !== want.sts)
			flag_mismatch($sformatf("result %0d: status %0d, expected %0d",
				checked, status, want.sts));
		if (alarm_valid !== want.alarm)
			flag_mismatch($sformatf("result %0d: alarm_valid %b, expected %b",
				checked, alarm_valid, want.alarm));
		if (alarm_seconds !== want.secs)
			flag_mismatch($sformatf("result %0d: alarm_seconds %h, expected %h",
				checked, alarm_seconds, want.secs));
		if (current_id !== want.cur)
			flag_mismatch($sformatf("result %0d: current_id %0d, expected %0d",
				checked, current_id, want.cur));
	endtask

	initial begin : drain
		int stall_left;
		int cyc;
		bit held;
		stall_left = 0;
		cyc = 0;
		held = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (out_valid && out_ready) check_outcome();
			if (!held && checked >= 400) begin
				held = 1'b1;
				stall_left = 500;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				stall_left = pick_gap(((cyc / 300) % 4) == 2);
				out_ready <= (stall_left == 0);
				if (stall_left > 0) stall_left--;
			end
		end
	end

	initial begin : stimulus
		timer_cmd_t c;
		int directed;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= dtt_pkg::OP_ADD;
		instance_id <= 4'd0;
		timer_type <= 4'd0;
		deadline <= 32'd0;
		now_seconds <= 32'd0;
		delta <= 32'd0;
		shift_down <= 1'b0;
		foreach (sts_hits[i]) sts_hits[i] = 0;
		clear_table();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			offer_cmd(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].rsp, 1'b0);
		directed = sent;
		for (int idx = 0; idx < RAND_N; idx++) begin
			c = roll_cmd(idx);
			offer_cmd(c, 1'b0, NO_RSP, ((idx / 150) % 4) == 1);
		end
		in_valid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Run covered %0d timer commands, %0d of them from the directed table;",
			sent, directed);
		$display("%0d results checked: ok %0d, rejected %0d, no timer %0d, passed %0d, %s",
			checked, sts_hits[dtt_pkg::STS_OK], sts_hits[dtt_pkg::STS_REJECTED],
			sts_hits[dtt_pkg::STS_NO_TIMER], sts_hits[dtt_pkg::STS_PASSED],
			$sformatf("bad id %0d, empty %0d, expired %0d.",
			sts_hits[dtt_pkg::STS_BAD_ID], sts_hits[dtt_pkg::STS_EMPTY],
			sts_hits[dtt_pkg::STS_EXPIRED]));
		if (mismatches == 0)
			$display("deadline_timer_table_core: match");
		else
			$display("deadline_timer_table_core: mismatch");
		$finish;
	end

	initial begin : watchdog
		#2_500_000;
		$display("deadline_timer_table_core: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/dtt_pkg.sv
rtl/core/dtt_alu.sv
rtl/core/dtt_slot_file.sv
rtl/core/deadline_timer_table_core.sv
tb/sv/deadline_timer_table_core_tb.sv
